[hw/rtl/rkd_pkg.sv]
package rkd_pkg;

  // data path width of modulus, exponent and ciphertext
  localparam int unsigned DW = 32;
  // width of the prime configuration registers
  localparam int unsigned PRIME_W = 16;
  localparam int unsigned PRIME_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_Q = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP = 2'd2;

  // commands from controller to datapath
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD_C,
    CMD_KEY_INIT,
    CMD_GCD_DIV,
    CMD_GCD_STEP,
    CMD_LCM_DIV,
    CMD_LCM_MUL,
    CMD_AMOD_DIV,
    CMD_EU_INIT,
    CMD_EU_DIV,
    CMD_EU_MUL,
    CMD_EU_STEP,
    CMD_KEY_GOOD,
    CMD_CMOD_DIV,
    CMD_POW_INIT,
    CMD_MUL_ACC,
    CMD_ACC_STEP,
    CMD_MUL_SQ,
    CMD_SQ_STEP,
    CMD_OUT_OK,
    CMD_OUT_ERR
  } cmd_e;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic p_small;
    logic rb_zero;
    logic m_small;
    logic ra_one;
    logic s0_zero;
    logic n_zero;
    logic exp_zero;
    logic exp_lsb;
  } stat_t;

endpackage

[hw/rtl/rkd_div.sv]
module rkd_div import rkd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dsr_q;
  logic [DW:0]   part;
  logic [DW:0]   diff;
  logic          take;

  // one restoring step: one quotient bit per cycle
  always_comb begin
    part = {rem_q, quo_q[DW-1]};
    diff = part - {1'b0, dsr_q};
    take = (part >= {1'b0, dsr_q});
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DW-1:0] : part[DW-1:0];
      quo_q <= {quo_q[DW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/rkd_mmul.sv]
module rkd_mmul import rkd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  input  logic [DW-1:0] m_i,
  output logic          done_o,
  output logic [DW-1:0] prod_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] acc_q;
  logic [DW-1:0] bits_q;
  logic [DW-1:0] a_q;
  logic [DW-1:0] m_q;
  logic [DW+1:0] sum;
  logic [DW+1:0] m1;
  logic [DW+1:0] m2;
  logic [DW+1:0] red;

  // double, add multiplicand for the current bit, reduce below m
  always_comb begin
    m1  = {2'b00, m_q};
    m2  = {1'b0, m_q, 1'b0};
    sum = {1'b0, acc_q, 1'b0} + (bits_q[DW-1] ? {2'b00, a_q} : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // accumulator, msb first over b
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      bits_q <= b_i;
      a_q    <= a_i;
      m_q    <= m_i;
    end else if (busy_q) begin
      acc_q  <= red[DW-1:0];
      bits_q <= {bits_q[DW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[hw/rtl/rkd_datapath.sv]
module rkd_datapath import rkd_pkg::*; #(
  parameter int unsigned PRIME_BITS = PRIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DW-1:0]        cfg_data_i,
  input  logic [DW-1:0]        ciphertext_i,
  input  cmd_e                 cmd_i,
  output stat_t                stat_o,
  output logic [DW-1:0]        plaintext_o
);

  localparam int unsigned PW = (PRIME_BITS < PRIME_W) ? PRIME_BITS : PRIME_W;

  logic [PW-1:0]   p_q, q_q;
  logic [DW-1:0]   r_q;
  logic [PW-1:0]   p1, q1;
  logic [2*PW-1:0] pq;
  logic [2*PW-1:0] lcm_prod;
  logic [DW-1:0]   c_q, n_q, m_q, s_q;
  logic [DW-1:0]   ra_q, rb_q, s0_q, s1_q, t_q;
  logic [DW-1:0]   base_q, acc_q, exp_q, res_q;
  logic [DW:0]     s_sub;
  logic            div_start, mul_start;
  logic [DW-1:0]   div_a, div_b, mul_a, mul_b, mul_m;
  logic            div_done, mul_done;
  logic [DW-1:0]   quot, rem, prod;

  // configuration registers, primes kept at their used width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= PW'(2);
      q_q <= PW'(3);
      r_q <= DW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRIME_P: p_q <= cfg_data_i[PW-1:0];
        CFG_PRIME_Q: q_q <= cfg_data_i[PW-1:0];
        CFG_PUB_EXP: r_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign p1       = p_q - 1'b1;
  assign q1       = q_q - 1'b1;
  assign pq       = p_q * q_q;
  assign lcm_prod = quot[PW-1:0] * q1;

  // s0 - prod modulo m
  assign s_sub = (s0_q >= prod) ? {1'b0, s0_q - prod}
                                : ({1'b0, s0_q} + {1'b0, m_q} - {1'b0, prod});

  // operand selection for the shared divider and modular multiplier
  always_comb begin
    div_start = 1'b1;
    div_a     = ra_q;
    div_b     = rb_q;
    unique case (cmd_i)
      CMD_GCD_DIV, CMD_EU_DIV: ;
      CMD_LCM_DIV: begin
        div_a = DW'(p1);
        div_b = ra_q;
      end
      CMD_AMOD_DIV: begin
        div_a = r_q;
        div_b = m_q;
      end
      CMD_CMOD_DIV: begin
        div_a = c_q;
        div_b = n_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    mul_start = 1'b1;
    mul_a     = base_q;
    mul_b     = base_q;
    mul_m     = n_q;
    unique case (cmd_i)
      CMD_MUL_SQ: ;
      CMD_MUL_ACC: mul_a = acc_q;
      CMD_EU_MUL: begin
        mul_a = s1_q;
        mul_b = quot;
        mul_m = m_q;
      end
      default: mul_start = 1'b0;
    endcase
  end

  rkd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  rkd_mmul u_mmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (mul_m),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // key and working registers, updated by command
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD_C: c_q <= ciphertext_i;
      CMD_KEY_INIT: begin
        n_q  <= DW'(pq);
        ra_q <= DW'(p1);
        rb_q <= DW'(q1);
      end
      CMD_GCD_STEP: begin
        ra_q <= rb_q;
        rb_q <= rem;
      end
      CMD_LCM_MUL: m_q <= DW'(lcm_prod);
      CMD_EU_INIT: begin
        ra_q <= rem;
        rb_q <= m_q;
        s0_q <= DW'(1);
        s1_q <= '0;
      end
      CMD_EU_MUL: t_q <= rem;
      CMD_EU_STEP: begin
        ra_q <= rb_q;
        rb_q <= t_q;
        s0_q <= s1_q;
        s1_q <= s_sub[DW-1:0];
      end
      CMD_KEY_GOOD: s_q <= s0_q;
      CMD_POW_INIT: begin
        base_q <= rem;
        acc_q  <= (n_q == DW'(1)) ? '0 : DW'(1);
        exp_q  <= s_q;
      end
      CMD_ACC_STEP: acc_q <= prod;
      CMD_SQ_STEP: begin
        base_q <= prod;
        exp_q  <= {1'b0, exp_q[DW-1:1]};
      end
      CMD_OUT_OK:  res_q <= acc_q;
      CMD_OUT_ERR: res_q <= '0;
      default: ;
    endcase
  end

  // status
  always_comb begin
    stat_o.div_done = div_done;
    stat_o.mul_done = mul_done;
    stat_o.p_small  = (p_q < PW'(2)) || (q_q < PW'(2));
    stat_o.rb_zero  = (rb_q == '0);
    stat_o.m_small  = (m_q <= DW'(1));
    stat_o.ra_one   = (ra_q == DW'(1));
    stat_o.s0_zero  = (s0_q == '0);
    stat_o.n_zero   = (n_q == '0);
    stat_o.exp_zero = (exp_q == '0);
    stat_o.exp_lsb  = exp_q[0];
  end

  assign plaintext_o = res_q;

endmodule

[hw/rtl/rkd_ctrl.sv]
module rkd_ctrl import rkd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_hit_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  key_error_o,
  input  stat_t stat_i,
  output cmd_e  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_KEY_INIT, ST_GCD_TEST, ST_GCD_WAIT, ST_LCM_WAIT, ST_AMOD,
    ST_AMOD_WAIT, ST_EU_TEST, ST_EU_DIV_WAIT, ST_EU_MUL_WAIT, ST_KEY_END,
    ST_DEC, ST_CMOD_WAIT, ST_POW_TEST, ST_ACC_WAIT, ST_SQ_START, ST_SQ_WAIT,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   key_ready_q, key_ready_d;
  logic   key_inv_q, key_inv_d;
  logic   err_q, err_d;
  logic   out_valid_q, out_valid_d;
  logic   key_error_q, key_error_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and command decode
  always_comb begin
    state_d     = state_q;
    key_ready_d = key_ready_q;
    key_inv_d   = key_inv_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    key_error_d = key_error_q;
    cmd_o       = CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD_C;
          state_d = key_ready_q ? ST_DEC : ST_KEY_INIT;
        end
      end
      ST_KEY_INIT: begin
        cmd_o = CMD_KEY_INIT;
        if (stat_i.p_small) begin
          key_inv_d   = 1'b1;
          key_ready_d = 1'b1;
          state_d     = ST_DEC;
        end else begin
          state_d = ST_GCD_TEST;
        end
      end
      ST_GCD_TEST: begin
        if (stat_i.rb_zero) begin
          cmd_o   = CMD_LCM_DIV;
          state_d = ST_LCM_WAIT;
        end else begin
          cmd_o   = CMD_GCD_DIV;
          state_d = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o   = CMD_GCD_STEP;
          state_d = ST_GCD_TEST;
        end
      end
      ST_LCM_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o   = CMD_LCM_MUL;
          state_d = ST_AMOD;
        end
      end
      ST_AMOD: begin
        if (stat_i.m_small) begin
          key_inv_d   = 1'b1;
          key_ready_d = 1'b1;
          state_d     = ST_DEC;
        end else begin
          cmd_o   = CMD_AMOD_DIV;
          state_d = ST_AMOD_WAIT;
        end
      end
      ST_AMOD_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o   = CMD_EU_INIT;
          state_d = ST_EU_TEST;
        end
      end
      ST_EU_TEST: begin
        if (stat_i.rb_zero) begin
          state_d = ST_KEY_END;
        end else begin
          cmd_o   = CMD_EU_DIV;
          state_d = ST_EU_DIV_WAIT;
        end
      end
      ST_EU_DIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o   = CMD_EU_MUL;
          state_d = ST_EU_MUL_WAIT;
        end
      end
      ST_EU_MUL_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o   = CMD_EU_STEP;
          state_d = ST_EU_TEST;
        end
      end
      ST_KEY_END: begin
        cmd_o       = CMD_KEY_GOOD;
        key_inv_d   = !stat_i.ra_one || stat_i.s0_zero;
        key_ready_d = 1'b1;
        state_d     = ST_DEC;
      end
      ST_DEC: begin
        if (key_inv_q || stat_i.n_zero) begin
          err_d   = 1'b1;
          state_d = ST_OUT;
        end else begin
          err_d   = 1'b0;
          cmd_o   = CMD_CMOD_DIV;
          state_d = ST_CMOD_WAIT;
        end
      end
      ST_CMOD_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o   = CMD_POW_INIT;
          state_d = ST_POW_TEST;
        end
      end
      ST_POW_TEST: begin
        if (stat_i.exp_zero) begin
          state_d = ST_OUT;
        end else if (stat_i.exp_lsb) begin
          cmd_o   = CMD_MUL_ACC;
          state_d = ST_ACC_WAIT;
        end else begin
          cmd_o   = CMD_MUL_SQ;
          state_d = ST_SQ_WAIT;
        end
      end
      ST_ACC_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o   = CMD_ACC_STEP;
          state_d = ST_SQ_START;
        end
      end
      ST_SQ_START: begin
        cmd_o   = CMD_MUL_SQ;
        state_d = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o   = CMD_SQ_STEP;
          state_d = ST_POW_TEST;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o       = err_q ? CMD_OUT_ERR : CMD_OUT_OK;
          out_valid_d = 1'b1;
          key_error_d = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // a register write invalidates the derived key
    if (cfg_hit_i) begin
      key_ready_d = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_ready_q <= 1'b0;
      key_inv_q   <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      key_error_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_ready_q <= key_ready_d;
      key_inv_q   <= key_inv_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      key_error_q <= key_error_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign key_error_o = key_error_q;

endmodule

[hw/rtl/rsa_key_derive_and_decrypt_unit.sv]
// textbook rsa receiver: derives the private key from two primes and a
// public exponent, then decrypts one ciphertext item at a time
// config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 prime p, 1 prime q, 2 public exponent); index 3 is ignored.
// a write marks the key stale; write only while the block is idle
// input channel: ciphertext_i with in_valid_i / in_ready_o; in_ready_o is
// high only while the block is idle, one item is worked at a time
// output channel: plaintext_o and key_error_o with out_valid_o /
// out_ready_i, held in an output register; the next item is taken while
// a result still waits, and its result waits until the register frees
// key derivation: the first item after a register write first runs key
// derivation (euclid steps on the divider and the modular multiplier);
// then the exponentiation reduces the base on the divider and takes up
// to one multiply and one square per exponent bit, all on the one
// shared modular multiplier
// an invalid key yields plaintext 0 with key_error 1
// reset: registers return to p=2, q=3, exponent 1; the key is stale
module rsa_key_derive_and_decrypt_unit import rkd_pkg::*; #(
  parameter int unsigned PRIME_BITS = PRIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DW-1:0]        ciphertext_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DW-1:0]        plaintext_o,
  output logic                 key_error_o
);

  cmd_e  cmd;
  stat_t stat;
  logic  cfg_hit;

  // only writes to an existing register make the key stale
  assign cfg_hit = cfg_we_i && ((cfg_idx_i == CFG_PRIME_P) || (cfg_idx_i == CFG_PRIME_Q) ||
                                (cfg_idx_i == CFG_PUB_EXP));

  rkd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_hit_i   (cfg_hit),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_error_o (key_error_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rkd_datapath #(
    .PRIME_BITS (PRIME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .ciphertext_i (ciphertext_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .plaintext_o  (plaintext_o)
  );

endmodule

[hw/rtl/rkd_checker.sv]
module rkd_props import rkd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [DW-1:0]        cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [DW-1:0]        ciphertext_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [DW-1:0]        plaintext_o,
  input logic                 key_error_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(plaintext_o) &&
    $stable(key_error_o))
    else $error("stalled result changed");

  // an error result carries zero plaintext
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_error_o |-> plaintext_o == '0)
    else $error("error result with nonzero plaintext");

  // one item at a time: busy right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while busy");

  // a result never appears in the cycle right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result too early");

endmodule

bind rsa_key_derive_and_decrypt_unit rkd_props u_rkd_props (.*);

[verif/rkd_checker.sv]
// watches the config port and both channels, predicts each plaintext
// and compares it with what the block returns
module rkd_checker import rkd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [DW-1:0]        ciphertext_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [DW-1:0]        plaintext_i,
  input  logic                 key_error_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DW-1:0] plain;
    logic          kerr;
  } plain_t;

  // shadow of the register file and the derived key
  logic [PRIME_W-1:0] sh_p, sh_q;
  logic [DW-1:0]      sh_r;
  logic [DW-1:0]      key_modulus, key_exp;
  logic               key_fresh, key_bad;
  plain_t             plain_q[$];

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // extended euclid, 0 when a has no inverse modulo m
  function automatic longint unsigned inv_mod(longint unsigned a, longint unsigned m);
    longint r0, r1, s0, s1, qt, t;
    r0 = longint'(a % m);
    r1 = longint'(m);
    s0 = 1;
    s1 = 0;
    while (r1 != 0) begin
      qt = r0 / r1;
      t = r0 - qt * r1;
      r0 = r1;
      r1 = t;
      t = s0 - qt * s1;
      s0 = s1;
      s1 = t;
    end
    if (r0 != 1) return 0;
    s0 = s0 % longint'(m);
    if (s0 < 0) s0 += longint'(m);
    return longint'(s0);
  endfunction

  function automatic logic [DW-1:0] pow_mod(longint unsigned b, logic [DW-1:0] e,
                                             longint unsigned n);
    longint unsigned acc;
    acc = 1 % n;
    b = b % n;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % n;
      b = (b * b) % n;
      e = e >> 1;
    end
    return acc[DW-1:0];
  endfunction

  function automatic void derive_key();
    longint unsigned msk, p, q, s, m;
    msk = (64'd1 << PRIME_BITS_DEF) - 1;
    p = longint'(sh_p) & msk;
    q = longint'(sh_q) & msk;
    s = 0;
    key_modulus = DW'(p * q);
    if (p >= 2 && q >= 2) begin
      m = ((p - 1) / gcd64(p - 1, q - 1)) * (q - 1);
      if (m > 1) s = inv_mod(longint'(sh_r), m);
    end
    key_exp = DW'(s);
    key_bad = (s == 0);
    key_fresh = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    plain_t exp_v;
    if (!rst_ni) begin
      sh_p = 2;
      sh_q = 3;
      sh_r = 1;
      key_modulus = '0;
      key_exp = '0;
      key_fresh = 1'b0;
      key_bad = 1'b0;
      plain_q.delete();
      errors_o = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRIME_P: begin sh_p = cfg_data_i[PRIME_W-1:0]; key_fresh = 1'b0; end
          CFG_PRIME_Q: begin sh_q = cfg_data_i[PRIME_W-1:0]; key_fresh = 1'b0; end
          CFG_PUB_EXP: begin sh_r = cfg_data_i; key_fresh = 1'b0; end
          default: ;
        endcase
      end
      // accepted ciphertext item
      if (in_valid_i && in_ready_i) begin
        if (!key_fresh) derive_key();
        if (key_bad || key_modulus == 0) begin
          exp_v.plain = '0;
          exp_v.kerr = 1'b1;
        end else begin
          exp_v.plain = pow_mod(longint'(ciphertext_i), key_exp, longint'(key_modulus));
          exp_v.kerr = 1'b0;
        end
        plain_q.push_back(exp_v);
      end
      // accepted plaintext item
      if (out_valid_i && out_ready_i) begin
        if (plain_q.size() == 0) begin
          $display("%0t: unexpected item plaintext %h key_error %b",
                   $time, plaintext_i, key_error_i);
          errors_o++;
        end else begin
          exp_v = plain_q.pop_front();
          if (plaintext_i !== exp_v.plain) begin
            $display("%0t: plaintext expected %h actual %h", $time, exp_v.plain, plaintext_i);
            errors_o++;
          end
          if (key_error_i !== exp_v.kerr) begin
            $display("%0t: key_error expected %b actual %b", $time, exp_v.kerr, key_error_i);
            errors_o++;
          end
        end
      end
    end
    pending_o = plain_q.size();
  end

endmodule

[verif/tb_top.sv]
module tb_top import rkd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 40000;

  logic                 clk_i, rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DW-1:0]        cfg_data_i;
  logic                 in_valid_i, in_ready_o;
  logic [DW-1:0]        ciphertext_i;
  logic                 out_valid_o, out_ready_i;
  logic [DW-1:0]        plaintext_o;
  logic                 key_error_o;
  int                   errors, pending;

  // idling knobs: percent per cycle, and a receiver hold-off request
  int unsigned send_idle_pct, recv_stall_pct, hold_req;
  int unsigned items_sent, keys_used;
  logic [DW-1:0] cur_n;

  rsa_key_derive_and_decrypt_unit i_dut (.*);

  rkd_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .ciphertext_i,
    .out_valid_i(out_valid_o), .out_ready_i, .plaintext_i(plaintext_o),
    .key_error_i(key_error_o), .errors_o(errors), .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stalls plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic send_item(logic [DW-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ciphertext_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // drain every result and let the block settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_key(logic [DW-1:0] p, logic [DW-1:0] q, logic [DW-1:0] r);
    wait_drained();
    write_reg(CFG_PRIME_P, p);
    write_reg(CFG_PRIME_Q, q);
    write_reg(CFG_PUB_EXP, r);
    cur_n = p[PRIME_W-1:0] * q[PRIME_W-1:0];
    keys_used++;
  endtask

  function automatic logic [DW-1:0] pick_prime();
    logic [PRIME_W-1:0] low_primes[19] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                           43, 47, 53, 59, 61, 251, 257};
    logic [PRIME_W-1:0] high_primes[5] = '{65521, 65519, 65497, 40009, 32749};
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 75) return low_primes[$urandom_range(18)];
    if (sel < 88) return high_primes[$urandom_range(4)];
    return $urandom;
  endfunction

  initial begin
    logic [DW-1:0] r_pick[4];
    logic [DW-1:0] r;
    logic [DW-1:0] c;
    r_pick = '{3, 5, 17, 65537};
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    ciphertext_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    items_sent = 0;
    keys_used = 1;
    cur_n = 6;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key p=2 q=3 r=1, ciphertext extremes and values past the modulus
    send_item(0);
    send_item(1);
    send_item(5);
    send_item(6);
    send_item(32'hFFFF_FFFF);
    // lcm equal to one
    set_key(2, 2, 1);
    send_item(4);
    // prime below two, upper data bits masked away
    set_key(32'hABCD_0001, 7, 5);
    send_item(3);
    set_key(0, 11, 3);
    send_item(3);
    // no inverse, and exponent a multiple of the lcm, and exponent zero
    set_key(5, 7, 6);
    send_item(2);
    set_key(5, 7, 12);
    send_item(2);
    set_key(5, 7, 0);
    send_item(2);
    // unused register index leaves the key in place
    set_key(5, 7, 5);
    send_item(34);
    wait_drained();
    write_reg(2'd3, 32'hFFFF_FFFF);
    send_item(35);
    // non-prime factors
    set_key(9, 15, 7);
    send_item(100);
    send_item(134);
    // largest primes and a wide exponent
    set_key(65521, 65519, 65537);
    send_item(0);
    send_item(32'hFFFF_FFFF);
    send_item(cur_n - 1);
    send_item(cur_n);
    // all-ones registers
    set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(12345);
    send_item(32'h8000_0000);

    // random keys and ciphertexts under each idling mode
    for (int ph = 0; ph < 8; ph++) begin
      r = ($urandom_range(1)) ? r_pick[$urandom_range(3)] : $urandom;
      set_key(pick_prime(), pick_prime(), r);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int k = 0; k < 31; k++) begin
        // long receiver hold-off so the block backs up against its input
        if (ph == 4 && k == 3) hold_req = 5000;
        c = $urandom;
        if (cur_n != 0 && $urandom_range(99) < 70) c = c % cur_n;
        send_item(c);
      end
    end

    // end of stimulus: drain and settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    $display("decrypted %0d ciphertexts over %0d keys, incl. invalid keys,", items_sent,
             keys_used);
    $display("non-prime factors, oversized ciphertexts and mixed stall patterns");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
